// ----- hdl/qsd_pkg.sv -----
package qsd_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_VALUE    = 2'd1,
    KIND_PAIR_END = 2'd2
  } kind_t;

  // escape progress
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2,
    ESC_SPARE = 2'd3
  } esc_t;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChSpace = 8'h20;

  // one decoded result
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } res_t;

  // all results caused by one request
  typedef struct packed {
    logic [CntW-1:0]           cnt;
    res_t [MaxResults-1:0]     items;
  } res_list_t;

  // decoder state carried between requests
  typedef struct packed {
    logic       in_value_part;
    esc_t       escape_stage;
    logic [7:0] held_digit;
    logic       pair_nonempty;
  } dec_state_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return r;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// ----- hdl/qsd_decode.sv -----
module qsd_decode (
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                end_of_query,
  input  qsd_pkg::dec_state_t st,
  output qsd_pkg::dec_state_t st_next,
  output qsd_pkg::res_list_t  res
);

  logic                    iv;
  qsd_pkg::esc_t           es;
  logic [7:0]              hd;
  logic                    pn;
  logic [qsd_pkg::CntW-1:0] n;
  logic                    do_plain;
  logic                    do_flush;
  qsd_pkg::kind_t          pk;

  // walk the byte through escape, plain byte and end of query handling
  always_comb begin
    iv       = st.in_value_part;
    es       = st.escape_stage;
    hd       = st.held_digit;
    pn       = st.pair_nonempty;
    n        = '0;
    res      = '0;
    do_plain = 1'b0;
    do_flush = 1'b0;

    // pending escape
    if (byte_present) begin
      if (es == qsd_pkg::ESC_PCT || es == qsd_pkg::ESC_DIGIT) begin
        if (qsd_pkg::is_hex(data_byte)) begin
          if (es == qsd_pkg::ESC_PCT) begin
            hd = data_byte;
            es = qsd_pkg::ESC_DIGIT;
          end else begin
            pk = iv ? qsd_pkg::KIND_VALUE : qsd_pkg::KIND_KEY;
            res.items[n[qsd_pkg::IdxW-1:0]] =
              '{data: {qsd_pkg::hex_val(hd), qsd_pkg::hex_val(data_byte)}, kind: pk};
            n  = n + 1'b1;
            es = qsd_pkg::ESC_NONE;
            hd = '0;
          end
        end else begin
          do_flush = 1'b1;
          do_plain = 1'b1;
        end
      end else begin
        es       = qsd_pkg::ESC_NONE;
        do_plain = 1'b1;
      end
    end

    // broken escape goes out literally
    pk = iv ? qsd_pkg::KIND_VALUE : qsd_pkg::KIND_KEY;
    if (do_flush) begin
      res.items[n[qsd_pkg::IdxW-1:0]] = '{data: qsd_pkg::ChPct, kind: pk};
      n = n + 1'b1;
      if (es == qsd_pkg::ESC_DIGIT) begin
        res.items[n[qsd_pkg::IdxW-1:0]] = '{data: hd, kind: pk};
        n = n + 1'b1;
      end
      es = qsd_pkg::ESC_NONE;
      hd = '0;
    end

    // byte outside any escape
    if (do_plain) begin
      if (data_byte == qsd_pkg::ChAmp) begin
        if (pn) begin
          res.items[n[qsd_pkg::IdxW-1:0]] = '{data: 8'h00, kind: qsd_pkg::KIND_PAIR_END};
          n = n + 1'b1;
        end
        iv = 1'b0;
        pn = 1'b0;
      end else begin
        pn = 1'b1;
        if (data_byte == qsd_pkg::ChPct) begin
          es = qsd_pkg::ESC_PCT;
        end else if (data_byte == qsd_pkg::ChEq && !iv) begin
          iv = 1'b1;
        end else if (data_byte == qsd_pkg::ChPlus) begin
          res.items[n[qsd_pkg::IdxW-1:0]] = '{data: qsd_pkg::ChSpace, kind: pk};
          n = n + 1'b1;
        end else begin
          res.items[n[qsd_pkg::IdxW-1:0]] = '{data: data_byte, kind: pk};
          n = n + 1'b1;
        end
      end
    end

    // end of query flushes the escape and closes the pair
    pk = iv ? qsd_pkg::KIND_VALUE : qsd_pkg::KIND_KEY;
    if (end_of_query) begin
      if (es == qsd_pkg::ESC_PCT || es == qsd_pkg::ESC_DIGIT) begin
        res.items[n[qsd_pkg::IdxW-1:0]] = '{data: qsd_pkg::ChPct, kind: pk};
        n = n + 1'b1;
        if (es == qsd_pkg::ESC_DIGIT) begin
          res.items[n[qsd_pkg::IdxW-1:0]] = '{data: hd, kind: pk};
          n = n + 1'b1;
        end
      end
      if (pn) begin
        res.items[n[qsd_pkg::IdxW-1:0]] = '{data: 8'h00, kind: qsd_pkg::KIND_PAIR_END};
        n = n + 1'b1;
      end
      iv = 1'b0;
      es = qsd_pkg::ESC_NONE;
      hd = '0;
      pn = 1'b0;
    end

    res.cnt               = n;
    st_next.in_value_part = iv;
    st_next.escape_stage  = es;
    st_next.held_digit    = hd;
    st_next.pair_nonempty = pn;
  end

endmodule

// ----- hdl/qsd_out_buf.sv -----
module qsd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  qsd_pkg::res_list_t res,
  output logic               free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output logic [1:0]         m_tuser,
  output logic               m_tlast
);

  qsd_pkg::res_t [qsd_pkg::MaxResults-1:0] ent;
  logic [qsd_pkg::CntW-1:0]                cnt;
  logic [qsd_pkg::IdxW-1:0]                idx;
  logic                                    pop;
  logic                                    at_last;

  assign m_tvalid = (cnt != '0);
  assign pop      = m_tvalid && m_tready;
  assign at_last  = ({1'b0, idx} == (cnt - 1'b1));
  assign free     = !m_tvalid || (pop && at_last);
  assign m_tdata  = ent[idx].data;
  assign m_tuser  = ent[idx].kind;
  assign m_tlast  = at_last;

  // result storage is payload only
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= res.items;
    end
  end

  // fill count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= res.cnt;
      idx <= '0;
    end else if (pop) begin
      if (at_last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= qsd_pkg::CntW'(qsd_pkg::MaxResults))
    else $error("result count out of range");

  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, idx} < cnt))
    else $error("read pointer past result count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load && m_tvalid) |-> (m_tready && at_last))
    else $error("results overwritten before delivery");

  a_run_advance: assert property (@(posedge clk) disable iff (rst)
    (pop && !at_last && !load) |=> (m_tvalid && idx == $past(idx) + 1'b1))
    else $error("run did not advance");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

// ----- hdl/query_string_decoder_unit.sv -----
// Streaming decoder for form-urlencoded query strings. Raw bytes enter on the
// slave side with tuser set when the byte is present and tlast marking the end
// of the query; decoded key bytes (tuser 0), value bytes (tuser 1) and pair-end
// markers (tuser 2, data zero) leave on the master side, tlast flagging the last
// result caused by one request. A byte is decoded in the cycle it is accepted and
// its results (up to four) are held in an output buffer that drains one per cycle
// while m_tready is high; a new request is taken while the buffer is empty or in
// the same cycle the last buffered result leaves.
module query_string_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] byte_present
  input  logic       s_tlast,   // end_of_query
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] item_kind
  output logic       m_tlast    // last_of_run
);

  qsd_pkg::dec_state_t st;
  qsd_pkg::dec_state_t st_next;
  qsd_pkg::res_list_t  res;
  logic                accept;
  logic                free;

  assign s_tready = free;
  assign accept   = s_tvalid && free;

  // decode one request against the current pair state
  qsd_decode u_decode (
    .data_byte    (s_tdata),
    .byte_present (s_tuser),
    .end_of_query (s_tlast),
    .st           (st),
    .st_next      (st_next),
    .res          (res)
  );

  // pair and escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // result buffer and output channel
  qsd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && (res.cnt != '0)),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
